// File: hw/rtl/lpgb_pkg.sv
`default_nettype none

package lpgb_pkg;

   // request function codes
   localparam logic [2:0] FN_SAMPLE      = 3'd0;
   localparam logic [2:0] FN_SCAN        = 3'd1;
   localparam logic [2:0] FN_MARK        = 3'd2;
   localparam logic [2:0] FN_CLEAR_MARKS = 3'd3;
   localparam logic [2:0] FN_READ        = 3'd4;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DISCARD = 2'd1;
   localparam logic [1:0] ST_OUTSIDE = 2'd2;

   // pixel levels
   localparam logic [7:0] PIX_MARK  = 8'd255;
   localparam logic [7:0] PIX_HIT   = 8'd128;
   localparam logic [7:0] PIX_EMPTY = 8'd0;
   localparam logic [7:0] CNT_MAX   = 8'd255;

   // CSR indexes and reset values
   localparam logic [7:0] CSR_MAX_RANGE   = 8'd0;
   localparam logic [7:0] CSR_INV_CELL    = 8'd1;
   localparam logic [7:0] CSR_ANGLE_START = 8'd2;
   localparam logic [7:0] CSR_ANGLE_STEP  = 8'd3;

   localparam logic [15:0] RST_MAX_RANGE   = 16'd65535;
   localparam logic [15:0] RST_INV_CELL    = 16'd656;
   localparam logic [15:0] RST_ANGLE_START = 16'd0;
   localparam logic [15:0] RST_ANGLE_STEP  = 16'd182;

   // CORDIC: Q1.15, gain-compensated start, 14 steps
   localparam logic signed [17:0] CORDIC_GAIN = 18'sd19898;
   localparam logic [3:0]         CORDIC_LAST = 4'd13;

   // atan(2^-i) in 1/65536 turn
   function automatic logic [13:0] atan_turn(input logic [3:0] step);
      case (step)
         4'd0:    return 14'd8192;
         4'd1:    return 14'd4836;
         4'd2:    return 14'd2555;
         4'd3:    return 14'd1297;
         4'd4:    return 14'd651;
         4'd5:    return 14'd326;
         4'd6:    return 14'd163;
         4'd7:    return 14'd81;
         4'd8:    return 14'd41;
         4'd9:    return 14'd20;
         4'd10:   return 14'd10;
         4'd11:   return 14'd5;
         4'd12:   return 14'd3;
         4'd13:   return 14'd1;
         default: return 14'd0;
      endcase
   endfunction

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROTATE,
      ST_MUL_XA,
      ST_MUL_XB,
      ST_MUL_YA,
      ST_MUL_YB,
      ST_LOCATE,
      ST_FETCH,
      ST_UPDATE,
      ST_RESPOND
   } lpgb_state_type;

   typedef struct packed {
      logic take;
      logic rotate;
      logic mul_a;
      logic mul_b;
      logic axis_y;
      logic locate;
      logic update;
      logic load_out;
      logic sweep;
      logic clr_cnt;
      logic clr_mark;
   } lpgb_cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic [2:0] req_func;
      logic       req_discard;
      logic       cordic_last;
      logic       in_grid;
      logic       out_free;
   } lpgb_sts_type;

   typedef struct packed {
      logic       cnt_we;
      logic [7:0] cnt_data;
      logic       mark_we;
   } lpgb_wr_type;

endpackage

`default_nettype wire

// File: hw/rtl/lpgb_if.sv
`default_nettype none

interface lpgb_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        func;
   logic [15:0]       range_mm;
   logic signed [7:0] cell_x;
   logic signed [7:0] cell_y;

   modport source (output valid, func, range_mm, cell_x, cell_y, input ready);
   modport sink   (input valid, func, range_mm, cell_x, cell_y, output ready);
endinterface

interface lpgb_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] out_x;
   logic signed [7:0] out_y;
   logic [7:0]        hit_count;
   logic [7:0]        pixel;
   logic [1:0]        status;

   modport source (output valid, out_x, out_y, hit_count, pixel, status, input ready);
   modport sink   (input valid, out_x, out_y, hit_count, pixel, status, output ready);
endinterface

interface lpgb_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  reg_index;
   logic [15:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lpgb_store.sv
`default_nettype none

module lpgb_store #(
   parameter int  GRID_WIDTH  = 64,
   parameter int  GRID_HEIGHT = 64,
   localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT,
   localparam int ADDR_W      = $clog2(CELLS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpgb_pkg::lpgb_cmd_type cmd,
   input  logic [ADDR_W-1:0]    addr,
   input  lpgb_pkg::lpgb_wr_type  wr,
   output logic [7:0]           cnt_rd,
   output logic                 mark_rd,
   output logic                 sweep_last
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   logic [7:0] cnt_mem  [CELLS];
   logic       mark_mem [CELLS];

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]        cnt_rd_ff;
   logic              mark_rd_ff;

   assign sweep_last = (clr_addr_ff == LAST_ADDR);
   assign cnt_rd     = cnt_rd_ff;
   assign mark_rd    = mark_rd_ff;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.sweep) begin
         clr_addr_in = sweep_last ? '0 : clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         if (cmd.clr_cnt) begin
            cnt_mem[clr_addr_ff] <= 8'd0;
         end
      end else if (wr.cnt_we) begin
         cnt_mem[addr] <= wr.cnt_data;
      end
      cnt_rd_ff <= cnt_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         if (cmd.clr_mark) begin
            mark_mem[clr_addr_ff] <= 1'b0;
         end
      end else if (wr.mark_we) begin
         mark_mem[addr] <= 1'b1;
      end
      mark_rd_ff <= mark_mem[addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/lpgb_dp.sv
`default_nettype none

module lpgb_dp #(
   parameter int  GRID_WIDTH  = 64,
   parameter int  GRID_HEIGHT = 64,
   localparam int ADDR_W      = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
   input  logic                   clock,
   input  logic                   reset,
   lpgb_req_if.sink               req_if,
   lpgb_rsp_if.source             rsp_if,
   lpgb_csr_if.sink               csr_if,
   input  lpgb_pkg::lpgb_cmd_type cmd,
   output lpgb_pkg::lpgb_sts_type sts,
   input  logic [7:0]             cnt_rd,
   input  logic                   mark_rd,
   output logic [ADDR_W-1:0]      mem_addr,
   output lpgb_pkg::lpgb_wr_type  mem_wr
);

   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int ROW_W = $clog2(GRID_HEIGHT);
   localparam logic signed [18:0] LO_X = 19'(1 - GRID_WIDTH / 2);
   localparam logic signed [18:0] HI_X = 19'(GRID_WIDTH / 2);
   localparam logic signed [18:0] LO_Y = 19'(1 - GRID_HEIGHT / 2);
   localparam logic signed [18:0] HI_Y = 19'(GRID_HEIGHT / 2);
   localparam logic [ADDR_W-1:0]  ROW_PITCH = ADDR_W'(GRID_WIDTH);

   // configuration
   logic [15:0] max_range_ff, inv_cell_ff, ang_start_ff, ang_step_ff;
   logic [15:0] beam_ff, beam_in;

   // item and working registers
   logic [2:0]         func_ff, func_in;
   logic [15:0]        range_ff, range_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [17:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [16:0] cz_ff, cz_in;
   logic [3:0]         iter_ff, iter_in;
   logic [32:0]        p1_ff, p1_in;
   logic               neg_ff, neg_in;
   logic signed [18:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [1:0]         res_st_ff, res_st_in;
   logic [7:0]         res_hc_ff, res_hc_in, res_px_ff, res_px_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [7:0]        rsp_hc_ff, rsp_hc_in, rsp_px_ff, rsp_px_in;
   logic [1:0]        rsp_st_ff, rsp_st_in;

   logic               accept, discard, is_cell_op;
   logic signed [17:0] dx, dy, cos_v, sin_v, t_sel, t_neg;
   logic signed [16:0] atan_s;
   logic [16:0]        t_mag;
   logic [48:0]        p2;
   logic signed [18:0] g_pos, g_val;
   logic signed [18:0] col_full, row_full;
   logic               in_grid;
   logic [7:0]         cnt_inc;

   assign req_if.ready = cmd.take;
   assign csr_if.ready = 1'b1;
   assign accept       = cmd.take & req_if.valid;
   assign discard      = (req_if.range_mm >= max_range_ff);
   assign is_cell_op   = (req_if.func == lpgb_pkg::FN_MARK) ||
                         (req_if.func == lpgb_pkg::FN_READ);

   // CSR writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= lpgb_pkg::RST_MAX_RANGE;
         inv_cell_ff  <= lpgb_pkg::RST_INV_CELL;
         ang_start_ff <= lpgb_pkg::RST_ANGLE_START;
         ang_step_ff  <= lpgb_pkg::RST_ANGLE_STEP;
      end else if (csr_if.valid) begin
         case (csr_if.reg_index)
            lpgb_pkg::CSR_MAX_RANGE:   max_range_ff <= csr_if.wdata;
            lpgb_pkg::CSR_INV_CELL:    inv_cell_ff  <= csr_if.wdata;
            lpgb_pkg::CSR_ANGLE_START: ang_start_ff <= csr_if.wdata;
            lpgb_pkg::CSR_ANGLE_STEP:  ang_step_ff  <= csr_if.wdata;
            default: ;
         endcase
      end
   end

   // beam angle advances on every sample, discarded or not; a scan reloads the start angle
   always_comb begin
      beam_in = beam_ff;
      if (accept && req_if.func == lpgb_pkg::FN_SAMPLE) begin
         beam_in = beam_ff + ang_step_ff;
      end else if (accept && req_if.func == lpgb_pkg::FN_SCAN) begin
         beam_in = ang_start_ff;
      end
   end

   // CORDIC step, quadrant fold-back afterwards
   assign dx     = cy_ff >>> iter_ff;
   assign dy     = cx_ff >>> iter_ff;
   assign atan_s = signed'(17'(lpgb_pkg::atan_turn(iter_ff)));

   always_comb begin
      case (quad_ff)
         2'd0: begin
            cos_v = cx_ff;
            sin_v = cy_ff;
         end
         2'd1: begin
            cos_v = -cy_ff;
            sin_v = cx_ff;
         end
         2'd2: begin
            cos_v = -cx_ff;
            sin_v = -cy_ff;
         end
         default: begin
            cos_v = cy_ff;
            sin_v = -cx_ff;
         end
      endcase
   end

   assign t_sel = cmd.axis_y ? sin_v : cos_v;
   assign t_neg = -t_sel;
   assign t_mag = t_sel[17] ? t_neg[16:0] : t_sel[16:0];

   assign p2    = 49'(p1_ff) * 49'(inv_cell_ff);
   assign g_pos = signed'({1'b0, p2[48:31]});
   assign g_val = neg_ff ? -g_pos : g_pos;

   // grid bounds and linear address
   assign in_grid  = (gx_ff >= LO_X) && (gx_ff <= HI_X) &&
                     (gy_ff >= LO_Y) && (gy_ff <= HI_Y);
   assign col_full = gx_ff - LO_X;
   assign row_full = gy_ff - LO_Y;

   assign cnt_inc = (cnt_rd == lpgb_pkg::CNT_MAX) ? cnt_rd : cnt_rd + 8'd1;

   always_comb begin
      func_in   = func_ff;
      range_in  = range_ff;
      quad_in   = quad_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      iter_in   = iter_ff;
      p1_in     = p1_ff;
      neg_in    = neg_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      addr_in   = addr_ff;
      res_st_in = res_st_ff;
      res_hc_in = res_hc_ff;
      res_px_in = res_px_ff;

      if (accept) begin
         func_in   = req_if.func;
         range_in  = req_if.range_mm;
         quad_in   = beam_ff[15:14];
         cx_in     = lpgb_pkg::CORDIC_GAIN;
         cy_in     = '0;
         cz_in     = signed'({3'b000, beam_ff[13:0]});
         iter_in   = '0;
         gx_in     = is_cell_op ? 19'(req_if.cell_x) : '0;
         gy_in     = is_cell_op ? 19'(req_if.cell_y) : '0;
         res_st_in = (req_if.func == lpgb_pkg::FN_SAMPLE && discard) ?
                     lpgb_pkg::ST_DISCARD : lpgb_pkg::ST_OK;
         res_hc_in = '0;
         res_px_in = lpgb_pkg::PIX_EMPTY;
      end

      if (cmd.rotate) begin
         if (!cz_ff[16]) begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            cz_in = cz_ff - atan_s;
         end else begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            cz_in = cz_ff + atan_s;
         end
         iter_in = iter_ff + 4'd1;
      end

      if (cmd.mul_a) begin
         p1_in  = 33'(range_ff) * 33'(t_mag);
         neg_in = t_sel[17];
      end

      if (cmd.mul_b) begin
         if (cmd.axis_y) begin
            gy_in = g_val;
         end else begin
            gx_in = g_val;
         end
      end

      if (cmd.locate) begin
         addr_in = ADDR_W'(row_full[ROW_W-1:0]) * ROW_PITCH +
                   ADDR_W'(col_full[COL_W-1:0]);
         if (!in_grid) begin
            res_st_in = lpgb_pkg::ST_OUTSIDE;
         end
      end

      if (cmd.update) begin
         case (func_ff)
            lpgb_pkg::FN_SAMPLE: begin
               res_hc_in = cnt_inc;
               res_px_in = mark_rd ? lpgb_pkg::PIX_MARK : lpgb_pkg::PIX_HIT;
            end
            lpgb_pkg::FN_MARK: begin
               res_hc_in = cnt_rd;
               res_px_in = lpgb_pkg::PIX_MARK;
            end
            default: begin
               res_hc_in = cnt_rd;
               if (mark_rd) begin
                  res_px_in = lpgb_pkg::PIX_MARK;
               end else if (cnt_rd != 8'd0) begin
                  res_px_in = lpgb_pkg::PIX_HIT;
               end else begin
                  res_px_in = lpgb_pkg::PIX_EMPTY;
               end
            end
         endcase
      end
   end

   assign mem_addr        = addr_ff;
   assign mem_wr.cnt_we   = cmd.update && (func_ff == lpgb_pkg::FN_SAMPLE);
   assign mem_wr.cnt_data = cnt_inc;
   assign mem_wr.mark_we  = cmd.update && (func_ff == lpgb_pkg::FN_MARK);

   // output register frees the engine while the receiver stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_hc_in    = rsp_hc_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_st_in    = rsp_st_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = gx_ff[7:0];
         rsp_y_in     = gy_ff[7:0];
         rsp_hc_in    = res_hc_ff;
         rsp_px_in    = res_px_ff;
         rsp_st_in    = res_st_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beam_ff      <= beam_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      range_ff  <= range_in;
      quad_ff   <= quad_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      iter_ff   <= iter_in;
      p1_ff     <= p1_in;
      neg_ff    <= neg_in;
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      addr_ff   <= addr_in;
      res_st_ff <= res_st_in;
      res_hc_ff <= res_hc_in;
      res_px_ff <= res_px_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_hc_ff <= rsp_hc_in;
      rsp_px_ff <= rsp_px_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_x     = rsp_x_ff;
   assign rsp_if.out_y     = rsp_y_ff;
   assign rsp_if.hit_count = rsp_hc_ff;
   assign rsp_if.pixel     = rsp_px_ff;
   assign rsp_if.status    = rsp_st_ff;

   assign sts.req_valid   = req_if.valid;
   assign sts.req_func    = req_if.func;
   assign sts.req_discard = discard;
   assign sts.cordic_last = (iter_ff == lpgb_pkg::CORDIC_LAST);
   assign sts.in_grid     = in_grid;
   assign sts.out_free    = !rsp_valid_ff || rsp_if.ready;

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("response raised without a load");

   a_sample_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && func_ff == lpgb_pkg::FN_SAMPLE) |=> (res_hc_ff != 8'd0))
      else $error("sample update left a zero hit count");

   a_outside_flag: assert property (@(posedge clock) disable iff (reset)
      (cmd.locate && !in_grid) |=> (res_st_ff == lpgb_pkg::ST_OUTSIDE))
      else $error("off-grid cell not flagged");

endmodule

`default_nettype wire

// File: hw/rtl/lpgb_ctrl.sv
`default_nettype none

module lpgb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  lpgb_pkg::lpgb_sts_type sts,
   input  logic                   sweep_last,
   output lpgb_pkg::lpgb_cmd_type cmd
);

   lpgb_pkg::lpgb_state_type state_ff, state_in;
   logic clr_cnt_ff, clr_cnt_in;
   logic clr_mark_ff, clr_mark_in;
   logic boot_ff, boot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lpgb_pkg::ST_CLEAR;
         clr_cnt_ff  <= 1'b1;
         clr_mark_ff <= 1'b1;
         boot_ff     <= 1'b1;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         clr_mark_ff <= clr_mark_in;
         boot_ff     <= boot_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_mark_in = clr_mark_ff;
      boot_in     = boot_ff;
      cmd         = '0;

      case (state_ff)
         lpgb_pkg::ST_CLEAR: begin
            cmd.sweep    = 1'b1;
            cmd.clr_cnt  = clr_cnt_ff;
            cmd.clr_mark = clr_mark_ff;
            if (sweep_last) begin
               // the power-up sweep produces no response
               state_in = boot_ff ? lpgb_pkg::ST_IDLE : lpgb_pkg::ST_RESPOND;
               boot_in  = 1'b0;
            end
         end
         lpgb_pkg::ST_IDLE: begin
            cmd.take = 1'b1;
            if (sts.req_valid) begin
               case (sts.req_func)
                  lpgb_pkg::FN_SAMPLE: begin
                     state_in = sts.req_discard ? lpgb_pkg::ST_RESPOND
                                                : lpgb_pkg::ST_ROTATE;
                  end
                  lpgb_pkg::FN_SCAN: begin
                     state_in    = lpgb_pkg::ST_CLEAR;
                     clr_cnt_in  = 1'b1;
                     clr_mark_in = 1'b0;
                  end
                  lpgb_pkg::FN_CLEAR_MARKS: begin
                     state_in    = lpgb_pkg::ST_CLEAR;
                     clr_cnt_in  = 1'b0;
                     clr_mark_in = 1'b1;
                  end
                  lpgb_pkg::FN_MARK, lpgb_pkg::FN_READ: begin
                     state_in = lpgb_pkg::ST_LOCATE;
                  end
                  default: begin
                     state_in = lpgb_pkg::ST_RESPOND;
                  end
               endcase
            end
         end
         lpgb_pkg::ST_ROTATE: begin
            cmd.rotate = 1'b1;
            if (sts.cordic_last) begin
               state_in = lpgb_pkg::ST_MUL_XA;
            end
         end
         lpgb_pkg::ST_MUL_XA: begin
            cmd.mul_a = 1'b1;
            state_in  = lpgb_pkg::ST_MUL_XB;
         end
         lpgb_pkg::ST_MUL_XB: begin
            cmd.mul_b = 1'b1;
            state_in  = lpgb_pkg::ST_MUL_YA;
         end
         lpgb_pkg::ST_MUL_YA: begin
            cmd.mul_a  = 1'b1;
            cmd.axis_y = 1'b1;
            state_in   = lpgb_pkg::ST_MUL_YB;
         end
         lpgb_pkg::ST_MUL_YB: begin
            cmd.mul_b  = 1'b1;
            cmd.axis_y = 1'b1;
            state_in   = lpgb_pkg::ST_LOCATE;
         end
         lpgb_pkg::ST_LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = sts.in_grid ? lpgb_pkg::ST_FETCH : lpgb_pkg::ST_RESPOND;
         end
         lpgb_pkg::ST_FETCH: begin
            state_in = lpgb_pkg::ST_UPDATE;
         end
         lpgb_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = lpgb_pkg::ST_RESPOND;
         end
         lpgb_pkg::ST_RESPOND: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = lpgb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpgb_pkg::ST_IDLE;
         end
      endcase
   end

   a_scan_sweeps_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpgb_pkg::ST_IDLE && sts.req_valid &&
       sts.req_func == lpgb_pkg::FN_SCAN)
      |=> (state_ff == lpgb_pkg::ST_CLEAR && clr_cnt_ff && !clr_mark_ff))
      else $error("new scan did not start a count sweep");

   a_rotate_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpgb_pkg::ST_MUL_XA)
      |-> $past(state_ff == lpgb_pkg::ST_ROTATE && sts.cordic_last))
      else $error("multiply started before rotation finished");

   a_fetch_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpgb_pkg::ST_FETCH)
      |-> $past(state_ff == lpgb_pkg::ST_LOCATE && sts.in_grid))
      else $error("store access for an off-grid cell");

endmodule

`default_nettype wire

// File: hw/rtl/lidar_polar_grid_binning.sv
// Lidar polar-to-grid binning.
// req_if carries one request per beam or command: a range sample, a new scan,
// mark cell, clear marks or read cell. rsp_if returns exactly one response per
// request, in order. csr_if writes max_range, inv_cell_size, angle_start and
// angle_step (indexes 0..3, others ignored); csr_if.ready is always high.
// From request accept to rsp_if.valid, a range sample passes the shared
// one-step-per-cycle CORDIC rotator, the two-stage multiply run once per
// axis, then locate, store read and update; a discarded sample or unused
// function goes straight to the response; mark or read passes locate, store
// read and update (a cell off the grid skips the store); new scan and clear
// marks run a sweep that zeroes one store entry per cycle. One request is in
// flight at a time, so a new request can be taken in the cycle after the
// previous response is loaded. Reset runs a sweep over both stores; req_if
// stays not ready during it. A finished response waits in an output register
// while rsp_if is stalled; the engine accepts the next request meanwhile and
// holds its own result until the output register frees.
`default_nettype none

module lidar_polar_grid_binning #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 64
) (
   input  logic       clock,
   input  logic       reset,
   lpgb_req_if.sink   req_if,
   lpgb_rsp_if.source rsp_if,
   lpgb_csr_if.sink   csr_if
);

   localparam int ADDR_W = $clog2(GRID_WIDTH * GRID_HEIGHT);

   lpgb_pkg::lpgb_cmd_type cmd;
   lpgb_pkg::lpgb_sts_type sts;
   lpgb_pkg::lpgb_wr_type  mem_wr;
   logic [ADDR_W-1:0]      mem_addr;
   logic [7:0]             cnt_rd;
   logic                   mark_rd;
   logic                   sweep_last;

   lpgb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .sts        (sts),
      .sweep_last (sweep_last),
      .cmd        (cmd)
   );

   lpgb_dp #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .csr_if   (csr_if),
      .cmd      (cmd),
      .sts      (sts),
      .cnt_rd   (cnt_rd),
      .mark_rd  (mark_rd),
      .mem_addr (mem_addr),
      .mem_wr   (mem_wr)
   );

   lpgb_store #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .addr       (mem_addr),
      .wr         (mem_wr),
      .cnt_rd     (cnt_rd),
      .mark_rd    (mark_rd),
      .sweep_last (sweep_last)
   );

endmodule

`default_nettype wire

// File: tb/lidar_polar_grid_binning_test.sv
module lidar_polar_grid_binning_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lpgb_pkg::*;

   localparam int GRID_W      = 64;
   localparam int GRID_H      = 64;
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 40;
   localparam int GAIN_Q15    = 19898;
   localparam int ATAN_TURNS [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                      41, 20, 10, 5, 3, 1};

   localparam logic [2:0] FN_FIRST_SPARE = 3'd5;
   localparam logic [2:0] FN_LAST_SPARE  = 3'd7;
   localparam logic [7:0] CSR_UNMAPPED   = 8'hFF;

   typedef struct packed {
      logic signed [7:0] x;
      logic signed [7:0] y;
      logic [7:0]        count;
      logic [7:0]        pixel;
      logic [1:0]        status;
   } cell_report_t;

   logic clock;
   logic reset;

   lpgb_req_if req_bus ();
   lpgb_rsp_if rsp_bus ();
   lpgb_csr_if csr_bus ();

   lidar_polar_grid_binning #(
      .GRID_WIDTH  (GRID_W),
      .GRID_HEIGHT (GRID_H)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // shadow of the block's state
   bit   [7:0]  grid_hits [GRID_W*GRID_H];
   bit          grid_marks [GRID_W*GRID_H];
   logic [15:0] beam_heading    = 16'd0;
   logic [15:0] cfg_max_range   = 16'd65535;
   logic [15:0] cfg_inv_cell    = 16'd656;
   logic [15:0] cfg_angle_start = 16'd0;
   logic [15:0] cfg_angle_step  = 16'd182;

   cell_report_t cell_reports [$];
   int errors        = 0;
   int req_gap_max   = 18;
   int rsp_gap_max   = 18;
   int rsp_hold      = 0;

   always #1 clock = ~clock;

   // 14-step CORDIC in Q1.15, quadrant taken from the top two angle bits
   function automatic void beam_trig(input logic [15:0] heading, output int cos_q15,
                                     output int sin_q15);
      int x, y, z, dx, dy, i;
      x = GAIN_Q15;
      y = 0;
      z = int'(heading[13:0]);
      for (i = 0; i < 14; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ATAN_TURNS[i];
         end else begin
            x += dx;
            y -= dy;
            z += ATAN_TURNS[i];
         end
      end
      case (heading[15:14])
         2'd0: begin cos_q15 = x;  sin_q15 = y;  end
         2'd1: begin cos_q15 = -y; sin_q15 = x;  end
         2'd2: begin cos_q15 = -x; sin_q15 = -y; end
         default: begin cos_q15 = y; sin_q15 = -x; end
      endcase
   endfunction

   // truncation toward zero: scale the magnitude, then restore the sign
   function automatic longint grid_coord(input logic [15:0] rng, input int trig);
      longint mag;
      mag = longint'(rng) * longint'(trig < 0 ? -trig : trig) * longint'(cfg_inv_cell);
      mag = mag >>> 31;
      return trig < 0 ? -mag : mag;
   endfunction

   function automatic int grid_slot(input longint gx, input longint gy);
      if (gx < 1 - GRID_W/2 || gx > GRID_W/2 || gy < 1 - GRID_H/2 || gy > GRID_H/2)
         return -1;
      return int'((gy - (1 - GRID_H/2)) * GRID_W + (gx - (1 - GRID_W/2)));
   endfunction

   function automatic cell_report_t cell_report_for(input logic [2:0] fn,
         input logic [15:0] rng, input logic signed [7:0] cx, input logic signed [7:0] cy);
      cell_report_t rep;
      logic [15:0]  heading;
      int           c, s, slot;
      longint       gx, gy;
      rep = '0;
      case (fn)
         FN_SAMPLE: begin
            heading      = beam_heading;
            beam_heading = beam_heading + cfg_angle_step;
            if (rng >= cfg_max_range) begin
               rep.status = ST_DISCARD;
            end else begin
               beam_trig(heading, c, s);
               gx    = grid_coord(rng, c);
               gy    = grid_coord(rng, s);
               rep.x = gx[7:0];
               rep.y = gy[7:0];
               slot  = grid_slot(gx, gy);
               if (slot < 0) begin
                  rep.status = ST_OUTSIDE;
               end else begin
                  if (grid_hits[slot] != CNT_MAX) grid_hits[slot]++;
                  rep.count = grid_hits[slot];
                  rep.pixel = grid_marks[slot] ? PIX_MARK : PIX_HIT;
               end
            end
         end
         FN_SCAN: begin
            foreach (grid_hits[i]) grid_hits[i] = '0;
            beam_heading = cfg_angle_start;
         end
         FN_MARK, FN_READ: begin
            rep.x = cx;
            rep.y = cy;
            slot  = grid_slot(cx, cy);
            if (slot < 0) begin
               rep.status = ST_OUTSIDE;
            end else begin
               if (fn == FN_MARK) grid_marks[slot] = 1'b1;
               rep.count = grid_hits[slot];
               rep.pixel = grid_marks[slot] ? PIX_MARK :
                           (rep.count != 0) ? PIX_HIT : PIX_EMPTY;
            end
         end
         FN_CLEAR_MARKS: begin
            foreach (grid_marks[i]) grid_marks[i] = 1'b0;
         end
         default: ;
      endcase
      return rep;
   endfunction

   // mostly inside the grid, now and then anywhere
   function automatic logic signed [7:0] grid_axis();
      if ($urandom_range(0, 4) == 0) return 8'($urandom);
      return 8'($urandom_range(0, GRID_W - 1) - (GRID_W/2 - 1));
   endfunction

   task automatic send_request(input logic [2:0] fn, input logic [15:0] rng,
                               input logic signed [7:0] cx, input logic signed [7:0] cy);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.func     <= fn;
      req_bus.range_mm <= rng;
      req_bus.cell_x   <= cx;
      req_bus.cell_y   <= cy;
      do @(posedge clock); while (!req_bus.ready);
      cell_reports.push_back(cell_report_for(fn, rng, cx, cy));
   endtask

   task automatic write_register(input logic [7:0] index, input logic [15:0] data);
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wdata     <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         CSR_MAX_RANGE:   cfg_max_range   = data;
         CSR_INV_CELL:    cfg_inv_cell    = data;
         CSR_ANGLE_START: cfg_angle_start = data;
         CSR_ANGLE_STEP:  cfg_angle_step  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_grid_config(input logic [15:0] max_range, input logic [15:0] inv_cell,
                                   input logic [15:0] angle_start, input logic [15:0] angle_step);
      write_register(CSR_MAX_RANGE, max_range);
      write_register(CSR_INV_CELL, inv_cell);
      write_register(CSR_ANGLE_START, angle_start);
      write_register(CSR_ANGLE_STEP, angle_step);
   endtask

   // every request yields a response, so an empty queue means the block is idle
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (cell_reports.size() != 0) @(posedge clock);
   endtask

   // a scan followed by beams, with reads, marks, mark clears, optional rescans and stray requests mixed in
   task automatic run_beam_sweep(input int beams, input bit with_scans);
      int          k, pick, shade, reach;
      logic [15:0] rng;
      reach = 34 * 65536 / int'(cfg_inv_cell);
      if (reach > 65535) reach = 65535;
      send_request(FN_SCAN, 16'($urandom), 8'($urandom), 8'($urandom));
      for (k = 0; k < beams; k++) begin
         pick = $urandom_range(0, 99);
         if (!with_scans && pick >= 92 && pick < 95) pick = 0;
         if (pick < 78) begin
            shade = $urandom_range(0, 19);
            if (shade < 14)      rng = 16'($urandom_range(0, reach));
            else if (shade < 17) rng = cfg_max_range + 16'($urandom_range(0, 2)) - 16'd1;
            else                 rng = 16'($urandom);
            send_request(FN_SAMPLE, rng, 8'($urandom), 8'($urandom));
         end else if (pick < 85) begin
            send_request(FN_READ, 16'($urandom), grid_axis(), grid_axis());
         end else if (pick < 90) begin
            send_request(FN_MARK, 16'($urandom), grid_axis(), grid_axis());
         end else if (pick < 92) begin
            send_request(FN_CLEAR_MARKS, 16'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 95) begin
            send_request(FN_SCAN, 16'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            send_request(3'($urandom_range(FN_FIRST_SPARE, FN_LAST_SPARE)), 16'($urandom),
                         8'($urandom), 8'($urandom));
         end
      end
   endtask

   // reset values in force; corners, discards, marks and the unused functions
   task automatic test_cell_operations();
      int f;
      send_request(FN_READ, 16'd0, 8'sd0, 8'sd0);
      send_request(FN_READ, 16'hFFFF, -8'sd128, -8'sd128);
      send_request(FN_READ, 16'h0000, 8'sd127, 8'sd127);
      send_request(FN_READ, 16'd0, -8'sd31, -8'sd31);
      send_request(FN_MARK, 16'd0, 8'sd32, 8'sd32);
      send_request(FN_READ, 16'd0, 8'sd33, 8'sd0);
      send_request(FN_READ, 16'd0, 8'sd0, -8'sd32);
      send_request(FN_SAMPLE, 16'd0, 8'sd0, 8'sd0);
      send_request(FN_SAMPLE, 16'hFFFF, 8'sd0, 8'sd0);
      send_request(FN_SAMPLE, 16'd65534, 8'sd0, 8'sd0);
      send_request(FN_SAMPLE, 16'd3000, 8'sd0, 8'sd0);
      send_request(FN_MARK, 16'd0, 8'sd0, 8'sd0);
      send_request(FN_READ, 16'd0, 8'sd0, 8'sd0);
      send_request(FN_MARK, 16'd0, 8'sd100, -8'sd100);
      send_request(FN_CLEAR_MARKS, 16'd0, 8'sd0, 8'sd0);
      send_request(FN_READ, 16'd0, 8'sd0, 8'sd0);
      send_request(FN_READ, 16'd0, 8'sd32, 8'sd32);
      for (f = FN_FIRST_SPARE; f <= FN_LAST_SPARE; f++)
         send_request(3'(f), 16'($urandom), 8'($urandom), 8'($urandom));
      send_request(FN_SCAN, 16'd0, 8'sd0, 8'sd0);
      send_request(FN_READ, 16'd0, 8'sd0, 8'sd0);
      send_request(FN_SAMPLE, 16'd1000, 8'sd0, 8'sd0);
   endtask

   task automatic test_beam_sweeps();
      int n;
      for (n = 0; n < 5; n++) begin
         settle();
         case (n)
            0: load_grid_config(16'd5000, 16'd656, 16'($urandom), 16'd182);
            1: load_grid_config(16'd0, 16'($urandom_range(1, 65535)), 16'($urandom),
                                16'($urandom));
            2: load_grid_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd16384);
            3: load_grid_config(16'($urandom), 16'($urandom_range(1, 65535)), 16'hFFFF,
                                16'hFFFF);
            default: load_grid_config(16'($urandom), 16'($urandom_range(1, 65535)),
                                      16'($urandom), 16'($urandom));
         endcase
         if (n == 1) write_register(CSR_UNMAPPED, 16'($urandom));
         req_gap_max = (n % 3 == 1) ? 0 : 18;
         rsp_gap_max = (n % 2 == 1) ? 0 : 18;
         run_beam_sweep(80, 1'b1);
      end
      req_gap_max = 18;
      rsp_gap_max = 18;
   endtask

   // coarsest cells and a fixed heading pile every beam onto the center cell
   task automatic test_hit_saturation();
      settle();
      load_grid_config(16'hFFFF, 16'd1, 16'($urandom), 16'd0);
      run_beam_sweep(340, 1'b0);
   endtask

   task automatic test_output_backpressure();
      int k;
      settle();
      load_grid_config(16'hFFFF, 16'd656, 16'd0, 16'd182);
      req_gap_max = 0;
      rsp_gap_max = 0;
      rsp_hold    = 300;
      for (k = 0; k < 24; k++)
         send_request(FN_SAMPLE, 16'($urandom_range(0, 3400)), 8'($urandom), 8'($urandom));
      settle();
      req_gap_max = 18;
      rsp_gap_max = 18;
   endtask

   initial begin : rsp_drain
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         gap      = (rsp_hold > 0) ? rsp_hold : $urandom_range(0, rsp_gap_max);
         rsp_hold = 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   always @(posedge clock) begin : check_reports
      cell_report_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (cell_reports.size() == 0) begin
            $display("%0t: response with no request pending: x=%0d y=%0d count=%0d status=%0d",
                     $time, rsp_bus.out_x, rsp_bus.out_y, rsp_bus.hit_count, rsp_bus.status);
            errors++;
         end else begin
            want = cell_reports.pop_front();
            if (rsp_bus.out_x !== want.x) begin
               $display("%0t: out_x expected %0d, got %0d", $time, want.x, rsp_bus.out_x);
               errors++;
            end
            if (rsp_bus.out_y !== want.y) begin
               $display("%0t: out_y expected %0d, got %0d", $time, want.y, rsp_bus.out_y);
               errors++;
            end
            if (rsp_bus.hit_count !== want.count) begin
               $display("%0t: hit_count expected %0d, got %0d", $time, want.count,
                        rsp_bus.hit_count);
               errors++;
            end
            if (rsp_bus.pixel !== want.pixel) begin
               $display("%0t: pixel expected %0d, got %0d", $time, want.pixel, rsp_bus.pixel);
               errors++;
            end
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status,
                        rsp_bus.status);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.func      = FN_SAMPLE;
      req_bus.range_mm  = 16'd0;
      req_bus.cell_x    = 8'sd0;
      req_bus.cell_y    = 8'sd0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = CSR_MAX_RANGE;
      csr_bus.wdata     = 16'd0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_cell_operations();
      test_beam_sweeps();
      test_hit_saturation();
      test_output_backpressure();

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && cell_reports.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
